@@ rtl/fpmnr_pkg.sv @@
// shared types and constants for the four-pad multitap nibble reader
// no dependencies
package fpmnr_pkg;

    localparam int unsigned LIVE_NIBBLES = 12;
    localparam int unsigned SIG_LEN      = 8;
    localparam int unsigned CNT_W        = 6;

    typedef logic [CNT_W-1:0] t_counter;
    typedef logic [3:0]       t_nibble;
    typedef logic [3:0]       t_store_idx;

    localparam t_counter COUNTER_LIMIT = 6'd32;
    localparam t_counter SIG_END       = 6'd8;
    localparam t_counter LIVE_END      = 6'd20;
    localparam t_nibble  NIBBLE_IDLE   = 4'hF;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // one accepted port access as seen by the state block
    typedef struct packed {
        logic valid;
        logic func;
        logic sel;
        logic hs;
    } t_access;

    // fixed id sequence sent before the pad data
    function automatic t_nibble signature_nibble(input logic [2:0] idx);
        t_nibble nib;
        unique case (idx)
            3'd0:    nib = 4'h3;
            3'd1:    nib = 4'hF;
            3'd2:    nib = 4'h0;
            3'd3:    nib = 4'h0;
            default: nib = 4'h1;
        endcase
        return nib;
    endfunction

endpackage

@@ rtl/four_pad_multitap_nibble_reader.sv @@
// Four-pad multitap nibble reader, top level.
// A read request's result is loaded into the result register at the accepting edge.
// Throughput: one request per cycle; o_ready drops only while a held result is not taken.
// Writes give no result and update the line levels and counter at the accepting edge.
// Synchronous active-low reset: lines high, counter 0, pad store all 0xF, no result pending.
// depends on fpmnr_pkg and fpmnr_port_state
module four_pad_multitap_nibble_reader (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [0:0]  i_func,
    input  logic [6:0]  i_write_value,
    input  logic [47:0] i_pad_buttons,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_read_value
);
    import fpmnr_pkg::*;

    logic       r_out_valid, n_out_valid;
    logic [6:0] r_read_value;
    logic       accept;
    logic       is_read;
    t_access    access;
    logic [6:0] read_now;

    // a new request goes in whenever the result register is free or being emptied
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign is_read = accept && (i_func == FUNC_READ);

    // bit 6 is select, bit 5 handshake; the rest of the written value is unused
    assign access.valid = accept;
    assign access.func  = i_func[0];
    assign access.sel   = i_write_value[6];
    assign access.hs    = i_write_value[5];

    fpmnr_port_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_access      (access),
        .i_pad_buttons (i_pad_buttons),
        .o_read_value  (read_now)
    );

    // result register: loaded by a read, cleared once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (is_read) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (is_read) begin
            r_read_value <= read_now;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_read_value;

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_read |=> o_valid && (o_read_value == $past(read_now)))
        else $error("read request lost its result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !accept)
        else $error("request accepted over a held result");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == FUNC_WRITE) && (!r_out_valid || i_ready)) |=> !o_valid)
        else $error("write produced a result");

endmodule

@@ rtl/fpmnr_port_state.sv @@
// line levels, nibble counter and pad nibble store of the multitap
// depends on fpmnr_pkg
module fpmnr_port_state (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpmnr_pkg::t_access   i_access,
    input  logic [47:0]          i_pad_buttons,
    output logic [6:0]           o_read_value
);
    import fpmnr_pkg::*;

    logic     r_sel, n_sel;
    logic     r_hs, n_hs;
    t_counter r_counter, n_counter;
    t_nibble  r_store [LIVE_NIBBLES];
    t_nibble  n_store [LIVE_NIBBLES];

    logic       is_write;
    logic       sel_rise;
    logic       line_change;
    t_nibble    nibble;
    t_store_idx store_idx;
    logic [4:0] store_off;

    assign is_write    = i_access.valid && (i_access.func == FUNC_WRITE);
    assign sel_rise    = !r_sel && i_access.sel;
    assign line_change = (r_sel != i_access.sel) || (r_hs != i_access.hs);

    always_comb begin
        n_sel     = r_sel;
        n_hs      = r_hs;
        n_counter = r_counter;
        n_store   = r_store;
        if (is_write) begin
            n_sel = i_access.sel;
            n_hs  = i_access.hs;
            priority if (sel_rise) begin
                n_counter = '0;
                for (int k = 0; k < LIVE_NIBBLES; k++) begin
                    n_store[k] = ~i_pad_buttons[4*k +: 4];
                end
            end else if (line_change) begin
                if (r_counter < COUNTER_LIMIT) begin
                    n_counter = r_counter + t_counter'(1);
                end
            end else begin
                // no line change, counter holds
                n_counter = r_counter;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel     <= 1'b1;
            r_hs      <= 1'b1;
            r_counter <= '0;
            for (int k = 0; k < LIVE_NIBBLES; k++) begin
                r_store[k] <= NIBBLE_IDLE;
            end
        end else begin
            r_sel     <= n_sel;
            r_hs      <= n_hs;
            r_counter <= n_counter;
            r_store   <= n_store;
        end
    end

    // slot past the live pads reads as idle
    assign store_off = r_counter[4:0] - 5'(SIG_END);
    assign store_idx = store_off[3:0];

    always_comb begin
        priority if (r_counter < SIG_END) begin
            nibble = signature_nibble(r_counter[2:0]);
        end else if (r_counter < LIVE_END) begin
            nibble = r_store[store_idx];
        end else begin
            nibble = NIBBLE_IDLE;
        end
    end

    assign o_read_value = {r_sel, r_hs, r_hs, nibble};

    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counter <= COUNTER_LIMIT)
        else $error("nibble counter beyond limit");

    a_rise_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_write && sel_rise) |=> (r_counter == '0) && r_sel)
        else $error("select rise did not restart sequence");

    a_read_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !is_write |=> $stable(r_counter) && $stable(r_sel) && $stable(r_hs))
        else $error("state changed without a write");

    a_quiet_write_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_write && !line_change) |=> $stable(r_counter))
        else $error("counter moved on write without line change");

endmodule

@@ tb/fpmnr_checker.sv @@
// response checker for the four-pad multitap nibble reader
// predicts read results from observed requests and compares them in order
// depends on fpmnr_pkg
module fpmnr_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [0:0]  i_func,
    input  logic [6:0]  i_write_value,
    input  logic [47:0] i_pad_buttons,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [6:0]  i_read_value,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    import fpmnr_pkg::*;

    localparam int STORE_DEPTH = 24;
    localparam int PRINT_CAP   = 40;

    logic       sel_line;
    logic       hs_line;
    t_counter   nib_count;
    t_nibble    pad_nibbles [STORE_DEPTH];
    logic [6:0] expected_reads [$];
    int         fail_count = 0;
    int         checked    = 0;

    function automatic t_nibble nibble_at_count();
        if (nib_count < SIG_END) begin
            case (nib_count[2:0])
                3'd0:       return 4'h3;
                3'd1:       return 4'hF;
                3'd2, 3'd3: return 4'h0;
                default:    return 4'h1;
            endcase
        end
        if (nib_count < COUNTER_LIMIT) begin
            return pad_nibbles[nib_count - SIG_END];
        end
        return NIBBLE_IDLE;
    endfunction

    task automatic latch_pads(input logic [47:0] pads);
        for (int k = 0; k < STORE_DEPTH; k++) begin
            if (k < LIVE_NIBBLES) begin
                pad_nibbles[k] = ~pads[4*k +: 4];
            end else begin
                pad_nibbles[k] = NIBBLE_IDLE;
            end
        end
    endtask

    task automatic apply_write(input logic [6:0] wv, input logic [47:0] pads);
        // select rising wins over the advance rule
        if (!sel_line && wv[6]) begin
            nib_count = '0;
            latch_pads(pads);
        end else if ((sel_line != wv[6]) || (hs_line != wv[5])) begin
            if (nib_count < COUNTER_LIMIT) begin
                nib_count = nib_count + 1'b1;
            end
        end
        sel_line = wv[6];
        hs_line  = wv[5];
    endtask

    task automatic report_error(input string what, input logic [6:0] got,
                                input logic [6:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP) begin
            $display("[%0t] error: %s, read_value got %02h want %02h",
                     $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic [6:0] want;
        if (!i_rst_n) begin
            sel_line  = 1'b1;
            hs_line   = 1'b1;
            nib_count = '0;
            for (int k = 0; k < STORE_DEPTH; k++) begin
                pad_nibbles[k] = NIBBLE_IDLE;
            end
            expected_reads.delete();
        end else begin
            // results first: a result never stems from the request of the same edge
            if (i_rsp_valid && i_rsp_ready) begin
                checked++;
                if (expected_reads.size() == 0) begin
                    report_error("result with no read outstanding", i_read_value, 7'h0);
                end else begin
                    want = expected_reads.pop_front();
                    if (i_read_value !== want) begin
                        report_error("wrong read result", i_read_value, want);
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_func == FUNC_READ) begin
                    expected_reads.push_back({sel_line, hs_line, hs_line, nibble_at_count()});
                end else begin
                    apply_write(i_write_value, i_pad_buttons);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_reads.size();
        o_checked    <= checked;
    end

endmodule

@@ tb/four_pad_multitap_nibble_reader_tb.sv @@
// testbench top for the four-pad multitap nibble reader
// drives port requests and result stalls, gives the verdict
// depends on fpmnr_pkg, fpmnr_checker and the reader rtl
module four_pad_multitap_nibble_reader_tb;
    import fpmnr_pkg::*;

    localparam int ITEMS        = 1100;
    localparam int IDLE_PCT     = 18;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_ready;
    logic [0:0]  i_func        = FUNC_READ;
    logic [6:0]  i_write_value = 7'h0;
    logic [47:0] i_pad_buttons = 48'h0;
    logic        o_valid;
    logic        i_ready       = 1'b0;
    logic [6:0]  o_read_value;

    int fail_count;
    int pending_reads;
    int results_seen;

    // test controls and counts; idle_on and hold_off_req also steer the receiver
    bit idle_on       = 1'b1;
    bit hold_off_req  = 1'b0;
    int sent          = 0;
    int n_reads       = 0;
    int n_writes      = 0;
    int n_polls       = 0;
    int stall_cycles  = 0;

    always #5 i_clk = ~i_clk;

    four_pad_multitap_nibble_reader uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_write_value (i_write_value),
        .i_pad_buttons (i_pad_buttons),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_value  (o_read_value)
    );

    fpmnr_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_func        (i_func),
        .i_write_value (i_write_value),
        .i_pad_buttons (i_pad_buttons),
        .i_rsp_valid   (o_valid),
        .i_rsp_ready   (i_ready),
        .i_read_value  (o_read_value),
        .o_fail_count  (fail_count),
        .o_pending     (pending_reads),
        .o_checked     (results_seen)
    );

    function automatic logic [47:0] rand_pads();
        return {16'($urandom_range(0, 65535)), 32'($urandom())};
    endfunction

    function automatic logic [4:0] rand_low();
        return 5'($urandom_range(0, 31));
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_request(input logic f, input logic [6:0] wv, input logic [47:0] pads);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= f;
        i_write_value <= wv;
        i_pad_buttons <= pads;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        sent++;
        if (f == FUNC_READ) begin
            n_reads++;
        end else begin
            n_writes++;
        end
    endtask

    // read with junk in the unused fields
    task automatic read_port();
        send_request(FUNC_READ, 7'($urandom_range(0, 127)), rand_pads());
    endtask

    // let everything outstanding come back, with the request line low
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reads != 0) begin
            @(posedge i_clk);
        end
    endtask

    // well-formed host poll: select low, select high with a pad snapshot,
    // then handshake toggles with reads spread through the nibble sequence
    task automatic poll_pads();
        logic hs;
        int   steps;
        hs = 1'($urandom_range(0, 1));
        send_request(FUNC_WRITE, {1'b0, hs, rand_low()}, rand_pads());
        hs = 1'($urandom_range(0, 1));
        send_request(FUNC_WRITE, {1'b1, hs, rand_low()}, rand_pads());
        if ($urandom_range(0, 1) == 1) begin
            read_port();
        end
        // some polls run long enough to hit the counter ceiling
        steps = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 30);
        for (int i = 0; i < steps; i++) begin
            if ($urandom_range(0, 99) >= 6) begin
                hs = ~hs;
            end
            send_request(FUNC_WRITE, {1'b1, hs, rand_low()}, rand_pads());
            if ($urandom_range(0, 99) < 55) begin
                read_port();
            end
        end
        n_polls++;
    endtask

    // noise: anything the fields allow
    task automatic random_burst();
        int len;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            send_request(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), rand_pads());
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
            end
        end
    end

    // watchdog on cycles where neither channel moves
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("four_pad_multitap_nibble_reader: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        bit hold_fired;
        bit drain_done;
        hold_fired = 1'b0;
        drain_done = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lines start high, counter at the first signature nibble
        read_port();
        send_request(FUNC_WRITE, 7'h7F, 48'h0);            // no line change, counter holds
        read_port();
        send_request(FUNC_WRITE, 7'h00, 48'h0);            // both lines drop, one advance
        read_port();
        send_request(FUNC_WRITE, 7'h60, 48'hFFFF_FFFF_FFFF); // select rise with hs change
        read_port();
        for (int i = 0; i < 8; i++) begin
            send_request(FUNC_WRITE, {1'b1, 1'(i), 5'h0}, 48'h0);
        end
        read_port();                                       // first stored nibble, all pressed
        send_request(FUNC_WRITE, 7'h20, 48'h0);            // select falls, counter advances
        read_port();
        send_request(FUNC_WRITE, 7'h40, 48'h0);            // rise, nothing pressed
        read_port();
        send_request(FUNC_WRITE, 7'h1F, 48'h0);
        read_port();

        // random part
        while (sent < ITEMS) begin
            idle_on = (sent < 250) || (sent >= 500);
            if (!hold_fired && sent >= 400) begin
                // stall results and keep reading so the block backs up
                hold_fired   = 1'b1;
                hold_off_req = 1'b1;
                repeat (6) read_port();
            end
            if (!drain_done && sent >= 750) begin
                drain_done = 1'b1;
                wait_drained();
            end
            if ($urandom_range(0, 99) < 70) begin
                poll_pads();
            end else begin
                random_burst();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d reads, %0d writes), %0d results compared",
                 sent, n_reads, n_writes, results_seen);
        $display("%0d pad polls through signature, pad data and counter ceiling", n_polls);
        if (fail_count == 0) begin
            $display("four_pad_multitap_nibble_reader: match");
        end else begin
            $display("four_pad_multitap_nibble_reader: mismatch");
        end
        $finish;
    end

endmodule
